FILE: rtl/tdf_pkg.sv
// Shared types and constants for the trial division factorizer.
package tdf_pkg;

  // Most results that one input number may produce.
  localparam int unsigned MaxResults = 30;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TWO   = 5'b00010,
    S_DIV   = 5'b00100,
    S_EVAL  = 5'b01000,
    S_FLUSH = 5'b10000
  } tdf_state_e;

  // Result status codes.
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

endpackage

FILE: rtl/tdf_div.sv
// Restoring divider, one quotient bit per cycle, shared by all odd trial divisors.
module tdf_div #(
  parameter int unsigned Width = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntBits = $clog2(Width + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [Width-1:0]   dq_q;
  logic [Width-1:0]   rem_q;
  logic [Width-1:0]   dvs_q;

  logic [Width:0]     trial;
  logic [Width:0]     diff;
  logic               ge;
  logic [Width-1:0]   rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial    = {rem_q, dq_q[Width-1]};
  assign diff     = trial - {1'b0, dvs_q};
  assign ge       = (trial >= {1'b0, dvs_q});
  assign rem_next = ge ? diff[Width-1:0] : trial[Width-1:0];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath; the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[Width-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

  // A new division is never started while one is running.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider restarted while busy");

  // Done follows the final step exactly.
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CntBits'(1)) |=> done_q)
    else $error("divider done missing after last step");

  // Done is never raised while a division is still running.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

FILE: rtl/trial_division_factorizer.sv
// Top level: sequencer, result staging and output register of the factorizer.
//
// Usage: one signed number enters on number_i when in_valid_i is high and
// in_stall_o is low. The block then gives the prime factors in ascending order,
// one output transaction per factor, repeats included; the final one carries
// last_o. An input of 1 or less gives one transaction with status_o = 1,
// factor_o = 0 and last_o = 1. At most 30 results come from one input.
// While a number is being worked on in_stall_o stays high; it drops once the
// final result has moved into the output register.
// Method: factors of two are stripped by a shift. Every odd trial divisor goes
// through the shared one-bit-per-cycle divider, which forms remainder / divisor
// and remainder % divisor together. A 32-bit prime near 2^31 tries about 23000
// divisors.
// Output: the result is held in a register while out_stall_i is high; the
// sequencer keeps one result staged so that the last flag is known, and it
// waits when both stages are full and out_stall_i is high.
// Reset clears all control state; no item is in progress afterwards.
module trial_division_factorizer #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [NUMBER_WIDTH-1:0] number_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [NUMBER_WIDTH-2:0]   factor_o,
  output logic                      status_o,
  output logic                      last_o
);

  import tdf_pkg::*;

  localparam int unsigned N = NUMBER_WIDTH - 1;

  tdf_state_e      state_q, state_d;
  logic [N-1:0]    n_q, n_d;
  logic [N-1:0]    dv_q, dv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            check_q, check_d;

  logic            pend_valid_q, pend_valid_d;
  logic [N-1:0]    pend_factor_q, pend_factor_d;
  logic            pend_status_q, pend_status_d;

  logic            out_valid_q, out_valid_d;
  logic [N-1:0]    out_factor_q;
  logic            out_status_q;
  logic            out_last_q;

  logic            can_push;
  logic            emit_ok;
  logic            emit;
  logic            push_pend;
  logic            push_last;
  logic            at_limit;
  logic            in_accept;

  logic            div_start;
  logic            div_done;
  logic [N-1:0]    div_quot;
  logic [N-1:0]    div_rem;

  // Shared divider for all odd trial divisors.
  tdf_div #(
    .Width (N)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_d),
    .divisor_i  (dv_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Handshake helpers.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign can_push   = !out_valid_q || !out_stall_i;
  assign emit_ok    = !pend_valid_q || can_push;
  assign at_limit   = (cnt_q == CntW'(MaxResults - 1));

  // Sequencer: strip twos, then try odd divisors through the shared divider.
  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    dv_d          = dv_q;
    cnt_d         = cnt_q;
    check_d       = check_q;
    pend_factor_d = pend_factor_q;
    pend_status_d = pend_status_q;
    emit          = 1'b0;
    push_last     = 1'b0;
    div_start     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (number_i[N] || (number_i[N-1:1] == '0)) begin
            emit          = 1'b1;
            pend_factor_d = '0;
            pend_status_d = StatusErr;
            state_d       = S_FLUSH;
          end else begin
            n_d     = number_i[N-1:0];
            cnt_d   = '0;
            state_d = S_TWO;
          end
        end
      end
      S_TWO: begin
        if (!n_q[0]) begin
          if (emit_ok) begin
            emit          = 1'b1;
            pend_factor_d = N'(2);
            pend_status_d = StatusOk;
            n_d           = {1'b0, n_q[N-1:1]};
            cnt_d         = cnt_q + 1'b1;
            if (at_limit) begin
              state_d = S_FLUSH;
            end
          end
        end else begin
          dv_d      = N'(3);
          check_d   = 1'b1;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (check_q && (dv_q > div_quot)) begin
          // Divisor squared exceeds the remainder: what is left, if above one, is prime.
          if (n_q > N'(1)) begin
            if (emit_ok) begin
              emit          = 1'b1;
              pend_factor_d = n_q;
              pend_status_d = StatusOk;
              state_d       = S_FLUSH;
            end
          end else begin
            state_d = S_FLUSH;
          end
        end else if (div_rem == '0) begin
          if (emit_ok) begin
            emit          = 1'b1;
            pend_factor_d = dv_q;
            pend_status_d = StatusOk;
            n_d           = div_quot;
            cnt_d         = cnt_q + 1'b1;
            if (at_limit) begin
              state_d = S_FLUSH;
            end else begin
              check_d   = 1'b0;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        end else begin
          dv_d      = dv_q + N'(2);
          check_d   = 1'b1;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_FLUSH: begin
        if (can_push) begin
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Staged result: a new one pushes the previous one to the output, and the flush pushes the last one.
  assign push_pend = (emit && pend_valid_q) || push_last;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (emit) begin
      pend_valid_d = 1'b1;
    end else if (push_last) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push_pend) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      check_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
      check_q      <= check_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    dv_q          <= dv_d;
    pend_factor_q <= pend_factor_d;
    pend_status_q <= pend_status_d;
    if (push_pend) begin
      out_factor_q <= pend_factor_q;
      out_status_q <= pend_status_q;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = out_factor_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // Nothing stays staged once the sequencer is back to idle.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("staged result left over in idle");

  // The divider only reports while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider done outside wait state");

  // An error transaction is always the final one and carries no factor.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_last_q && (out_factor_q == '0)))
    else $error("error result malformed");

  // The result count never passes the limit while work is in progress.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TWO || state_q == S_DIV || state_q == S_EVAL)
      |-> (cnt_q < CntW'(MaxResults)))
    else $error("result count beyond limit");

  // Leaving the flush state always hands over the final result.
  a_flush_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && can_push) |=> (out_valid_q && out_last_q))
    else $error("final result not delivered on flush");

endmodule

FILE: bench/testbench.sv
// Testbench for the trial division factorizer: directed and random numbers, checked per factor.
`timescale 1ns / 1ps

module testbench;
  import tdf_pkg::*;

  localparam int unsigned NumberWidth = 32;
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned DrainCycles = 200;

  // One factor result as the block reports it.
  typedef struct packed {
    logic [NumberWidth-2:0] factor;
    logic                   status;
    logic                   last;
  } factor_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [NumberWidth-1:0] number_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [NumberWidth-2:0]        factor_o;
  logic                          status_o;
  logic                          last_o;

  factor_result_t expected_factors[$];
  factor_result_t wanted;
  int unsigned    error_count;
  int unsigned    sender_idle_pct;
  int unsigned    receiver_stall_pct;
  logic           hold_off;

  trial_division_factorizer #(
    .NUMBER_WIDTH(NumberWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .number_i   (number_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .factor_o   (factor_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  // Free-running clock, 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Works out the factor list of one number and queues it in order.
  function automatic void predict_factors(input logic signed [NumberWidth-1:0] value);
    longint unsigned remaining;
    longint unsigned divisor;
    factor_result_t  found[$];
    if (value <= 1) begin
      expected_factors.push_back('{factor: '0, status: StatusErr, last: 1'b1});
      return;
    end
    remaining = longint'(value);
    // Strip the factors of two first.
    while (remaining[0] == 1'b0 && found.size() < MaxResults) begin
      remaining = remaining >> 1;
      found.push_back('{factor: (NumberWidth-1)'(2), status: StatusOk, last: 1'b0});
    end
    // Odd trial divisors while the divisor squared stays within the remainder.
    divisor = 3;
    while (divisor <= remaining / divisor && found.size() < MaxResults) begin
      if (remaining % divisor == 0) begin
        remaining = remaining / divisor;
        found.push_back('{factor: divisor[NumberWidth-2:0], status: StatusOk, last: 1'b0});
      end else begin
        divisor = divisor + 2;
      end
    end
    // Whatever is left above one is itself prime.
    if (remaining > 1 && found.size() < MaxResults) begin
      found.push_back('{factor: remaining[NumberWidth-2:0], status: StatusOk, last: 1'b0});
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_factors.push_back(found[i]);
  endfunction

  // Mostly smooth numbers of random size, with some rejected values mixed in.
  function automatic logic signed [NumberWidth-1:0] random_number();
    int unsigned     pick;
    longint unsigned product;
    longint unsigned cap;
    longint unsigned step;
    pick = $urandom_range(99);
    if (pick < 10) return {1'b1, 31'($urandom)};
    if (pick < 14) return NumberWidth'($urandom_range(0, 1));
    product = 1;
    cap = 64'd1 << $urandom_range(3, 31);
    // Sometimes one larger cofactor, so the last remainder can be a bigger prime.
    if (pick < 40) product = $urandom_range(2, 16383);
    forever begin
      step = $urandom_range(2, 127);
      if (product * step >= cap && product > 1) break;
      product = product * step;
    end
    return product[NumberWidth-1:0];
  endfunction

  // Offers one number and waits until the block takes it.
  task automatic send_number(input logic signed [NumberWidth-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    number_i   = value;
    do @(posedge clk_i); while (in_stall_o);
    predict_factors(value);
  endtask

  // Drops valid once the last number of a test has been taken.
  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic test_rejected_inputs();
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(-2);
    send_number(32'sh8000_0000);
    stop_sending();
  endtask

  task automatic test_small_factors();
    send_number(2);
    send_number(3);
    send_number(4);
    send_number(9);
    send_number(25);
    send_number(121);
    send_number(30);
    send_number(8633);
    send_number(2000006);
    // Thirty twos, the longest list a 32-bit number can give.
    send_number(32'sd1073741824);
    send_number(32'sd1162261467);
    send_number(32'sd1338557220);
    stop_sending();
  endtask

  task automatic test_field_extremes();
    send_number(32'sd2147483646);
    send_number(32'sd1073741823);
    // Largest positive value is prime, so the full divisor sweep runs.
    send_number(32'sd2147483647);
    stop_sending();
  endtask

  task automatic test_random_numbers(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_number(random_number());
    stop_sending();
  endtask

  // Receiver holds off for a long stretch while more numbers are offered.
  task automatic test_output_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_number(32'sd1073741824);
        send_number(32'sd1162261467);
        send_number(32'sd1338557220);
        stop_sending();
      end
    join
  endtask

  // Waits until every expected factor has come out.
  task automatic wait_for_drain();
    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver side: random stalls, or a forced hold-off.
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < receiver_stall_pct);
  end

  // Compares each transaction on the output with the oldest expected factor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_factors.size() == 0) begin
        $display("%0t: unexpected result factor %0d status %0b last %0b",
                 $time, factor_o, status_o, last_o);
        error_count++;
      end else begin
        wanted = expected_factors.pop_front();
        if (factor_o !== wanted.factor) begin
          $display("%0t: factor expected %0d, got %0d", $time, wanted.factor, factor_o);
          error_count++;
        end
        if (status_o !== wanted.status) begin
          $display("%0t: status expected %0b, got %0b", $time, wanted.status, status_o);
          error_count++;
        end
        if (last_o !== wanted.last) begin
          $display("%0t: last expected %0b, got %0b", $time, wanted.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    error_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off           = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    number_i           = '0;
    out_stall_i        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_rejected_inputs();
    test_small_factors();
    test_field_extremes();
    test_random_numbers(25, 0, 0);
    test_random_numbers(25, 62, 0);
    test_random_numbers(25, 0, 62);
    test_random_numbers(25, 12, 12);
    test_output_backpressure();
    wait_for_drain();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
